// ----- hdl/tlpc_pkg.sv -----
// shared types and constants of the tank level pump controller
`default_nettype none

package tlpc_pkg;

    // field widths
    localparam int T_W        = 16;   // echo time in microseconds
    localparam int CM_W       = 10;   // distance registers in whole cm
    localparam int PCT_W      = 7;    // trigger percentage
    localparam int LVL_W      = 8;    // stored level
    localparam int MODE_W     = 3;
    localparam int MARGIN_W   = 6;    // lower margin in cm

    // echo time to Q8 cm: (t * 281) >> 6
    localparam int ECHO_SCALE = 281;
    localparam int ECHO_SC_W  = 9;
    localparam int ECHO_SHIFT = 6;
    localparam int PROD_W     = T_W + ECHO_SC_W;
    localparam int DQ_W       = PROD_W - ECHO_SHIFT;
    localparam int FRAC_W     = 8;

    // percentage mapping
    localparam int NUM_SCALE  = 100;
    localparam int NUM_W      = 17;   // |(d - empty) * 100| fits here
    localparam int CNT_W      = 5;    // divider step counter, holds NUM_W
    localparam int P_W        = NUM_W + 1;
    localparam int LVL_MAX    = 255;

    // event codes on the input
    localparam logic [MODE_W-1:0] MODE_ECHO    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUTTON  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RMODE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RRELAY  = 3'd4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd2;

    localparam logic [CM_W-1:0]  EMPTY_RST   = 10'd160;
    localparam logic [CM_W-1:0]  FULL_RST    = 10'd20;
    localparam logic [PCT_W-1:0] TRIGGER_RST = 7'd20;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        OP_ECHO,
        OP_BUTTON,
        OP_TOGGLE,
        OP_RMODE,
        OP_RRELAY,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [DQ_W-1:0] dq;
        logic            sv;
    } t_item;

    typedef struct packed {
        logic [CM_W-1:0]  empty_cm;
        logic [CM_W-1:0]  full_cm;
        logic [PCT_W-1:0] trigger;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_back_state;

endpackage

`default_nettype wire

// ----- hdl/tlpc_in_if.sv -----
// event channel interface
`default_nettype none

interface tlpc_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlpc_pkg::MODE_W-1:0]  mode;
    logic [tlpc_pkg::T_W-1:0]     echo_time_us;
    logic                         set_value;

    modport source (output valid, output mode, output echo_time_us, output set_value,
                    input ready);
    modport sink   (input valid, input mode, input echo_time_us, input set_value,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/tlpc_out_if.sv -----
// result channel interface
`default_nettype none

interface tlpc_out_if;
    logic                         valid;
    logic                         ready;
    logic [tlpc_pkg::LVL_W-1:0]   level_percent;
    logic                         level_updated;
    logic                         pump_on;
    logic                         auto_active;

    modport source (output valid, output level_percent, output level_updated,
                    output pump_on, output auto_active, input ready);
    modport sink   (input valid, input level_percent, input level_updated,
                    input pump_on, input auto_active, output ready);
endinterface

`default_nettype wire

// ----- hdl/tlpc_front.sv -----
// front end: accepts events, decodes them and scales the echo time
`default_nettype none

module tlpc_front (
    tlpc_in_if.sink              i_evt,
    input  wire logic            i_full,
    output logic                 o_push,
    output tlpc_pkg::t_item      o_item
);

    logic [tlpc_pkg::PROD_W-1:0] prod;

    assign i_evt.ready = !i_full;
    assign o_push      = i_evt.valid && !i_full;

    // distance in Q14 cm, Q8 after dropping ECHO_SHIFT bits
    assign prod = tlpc_pkg::PROD_W'(i_evt.echo_time_us)
                * tlpc_pkg::PROD_W'(tlpc_pkg::ECHO_SCALE);

    always_comb begin
        o_item.dq = prod[tlpc_pkg::PROD_W-1:tlpc_pkg::ECHO_SHIFT];
        o_item.sv = i_evt.set_value;
        unique case (i_evt.mode)
            tlpc_pkg::MODE_ECHO:   o_item.op = tlpc_pkg::OP_ECHO;
            tlpc_pkg::MODE_BUTTON: o_item.op = tlpc_pkg::OP_BUTTON;
            tlpc_pkg::MODE_TOGGLE: o_item.op = tlpc_pkg::OP_TOGGLE;
            tlpc_pkg::MODE_RMODE:  o_item.op = tlpc_pkg::OP_RMODE;
            tlpc_pkg::MODE_RRELAY: o_item.op = tlpc_pkg::OP_RRELAY;
            default:               o_item.op = tlpc_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/tlpc_fifo.sv -----
// short queue of decoded events between front and back
`default_nettype none

module tlpc_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tlpc_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output tlpc_pkg::t_item      o_head,
    output logic                 o_empty
);

    tlpc_pkg::t_item                r_mem [tlpc_pkg::QDEPTH];
    logic [tlpc_pkg::QPTR_W-1:0]    r_wr;
    logic [tlpc_pkg::QPTR_W-1:0]    r_rd;
    logic [tlpc_pkg::QCNT_W-1:0]    r_cnt;
    logic [tlpc_pkg::QCNT_W-1:0]    n_cnt;

    assign o_full  = (r_cnt == tlpc_pkg::QCNT_W'(tlpc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tlpc_back.sv -----
// back end: applies events to pump and mode state, maps level with a serial divider
`default_nettype none

module tlpc_back #(
    parameter int LOWER_MARGIN_CM = 15
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlpc_pkg::t_cfg  i_cfg,
    input  wire tlpc_pkg::t_item i_head,
    input  wire logic            i_empty,
    output logic                 o_pop,
    tlpc_out_if.source           o_res
);

    localparam logic [tlpc_pkg::CM_W:0] MARGIN = (tlpc_pkg::CM_W + 1)'(LOWER_MARGIN_CM);

    tlpc_pkg::t_back_state          r_st;
    tlpc_pkg::t_back_state          n_st;
    logic [tlpc_pkg::CNT_W-1:0]     r_cnt;

    logic                           r_pump;
    logic                           r_auto;
    logic [tlpc_pkg::LVL_W-1:0]     r_level;

    logic                           r_out_valid;
    logic [tlpc_pkg::LVL_W-1:0]     r_out_level;
    logic                           r_out_upd;
    logic                           r_out_pump;
    logic                           r_out_auto;

    // divider
    logic [tlpc_pkg::NUM_W-1:0]     r_quo;
    logic [tlpc_pkg::CM_W-1:0]      r_rem;
    logic [tlpc_pkg::CM_W-1:0]      r_div;
    logic                           r_neg;
    logic                           r_zero;
    logic                           r_near;

    logic                           out_free;
    logic                           load_ev;
    logic                           load_fin;
    logic                           div_start;

    logic [tlpc_pkg::CM_W:0]        lo_diff;
    logic                           lo_ok;
    logic                           hi_ok;
    logic                           near;
    logic                           echo_go;
    logic [tlpc_pkg::CM_W-1:0]      d_cm;
    logic [tlpc_pkg::CM_W-1:0]      diff;
    logic [tlpc_pkg::NUM_W-1:0]     num_mag;
    logic                           den_pos;
    logic                           den_zero;
    logic [tlpc_pkg::CM_W-1:0]      den_mag;
    logic                           ev_pump;
    logic                           ev_auto;

    logic [tlpc_pkg::CM_W:0]        trial;
    logic                           qbit;

    logic [tlpc_pkg::P_W-1:0]       p_val;
    logic                           below;
    logic [tlpc_pkg::LVL_W-1:0]     fin_level;
    logic                           fin_pump;

    assign out_free = !r_out_valid || o_res.ready;

    // range check and divider operands for the head event
    always_comb begin
        lo_diff  = {1'b0, i_cfg.full_cm} - MARGIN;
        lo_ok    = lo_diff[tlpc_pkg::CM_W]
                 || (i_head.dq > {1'b0, lo_diff[tlpc_pkg::CM_W-1:0], 8'b0});
        hi_ok    = i_head.dq < {1'b0, i_cfg.empty_cm, 8'b0};
        near     = i_head.dq < {1'b0, i_cfg.full_cm, 8'b0};
        echo_go  = (i_head.op == tlpc_pkg::OP_ECHO) && lo_ok && hi_ok;
        d_cm     = i_head.dq[tlpc_pkg::FRAC_W +: tlpc_pkg::CM_W];
        diff     = i_cfg.empty_cm - d_cm;
        num_mag  = tlpc_pkg::NUM_W'(diff) * tlpc_pkg::NUM_W'(tlpc_pkg::NUM_SCALE);
        den_pos  = i_cfg.full_cm > i_cfg.empty_cm;
        den_zero = i_cfg.full_cm == i_cfg.empty_cm;
        den_mag  = den_pos ? (i_cfg.full_cm - i_cfg.empty_cm)
                           : (i_cfg.empty_cm - i_cfg.full_cm);
    end

    // button and remote events
    always_comb begin
        ev_pump = r_pump;
        ev_auto = r_auto;
        unique case (i_head.op)
            tlpc_pkg::OP_BUTTON: begin
                if (r_auto) begin
                    ev_pump = 1'b0;
                end
                ev_auto = !r_auto;
            end
            tlpc_pkg::OP_TOGGLE: begin
                if (!r_auto) begin
                    ev_pump = !r_pump;
                end
            end
            tlpc_pkg::OP_RMODE: begin
                ev_auto = i_head.sv;
                if (!i_head.sv) begin
                    ev_pump = 1'b0;
                end
            end
            tlpc_pkg::OP_RRELAY: begin
                if (!r_auto) begin
                    ev_pump = i_head.sv;
                end
            end
            default: begin
            end
        endcase
    end

    // restoring divider step
    always_comb begin
        trial = {r_rem, r_quo[tlpc_pkg::NUM_W-1]};
        qbit  = trial >= {1'b0, r_div};
    end

    // finishing an echo: signed level, clamp, hysteresis
    always_comb begin
        if (r_zero) begin
            p_val = '0;
        end else if (r_neg) begin
            p_val = -{1'b0, r_quo};
        end else begin
            p_val = {1'b0, r_quo};
        end
        below = $signed(p_val) < $signed(tlpc_pkg::P_W'(i_cfg.trigger));
        if (r_zero || r_neg) begin
            fin_level = '0;
        end else if (r_quo > tlpc_pkg::NUM_W'(tlpc_pkg::LVL_MAX)) begin
            fin_level = tlpc_pkg::LVL_W'(tlpc_pkg::LVL_MAX);
        end else begin
            fin_level = r_quo[tlpc_pkg::LVL_W-1:0];
        end
        fin_pump = r_pump;
        if (r_auto && below) begin
            fin_pump = 1'b1;
        end
        if (r_auto && r_near) begin
            fin_pump = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            tlpc_pkg::ST_IDLE: begin
                if (!i_empty && out_free && echo_go) begin
                    n_st = tlpc_pkg::ST_DIV;
                end
            end
            tlpc_pkg::ST_DIV: begin
                if (r_cnt == tlpc_pkg::CNT_W'(1)) begin
                    n_st = tlpc_pkg::ST_FIN;
                end
            end
            tlpc_pkg::ST_FIN: begin
                if (out_free) begin
                    n_st = tlpc_pkg::ST_IDLE;
                end
            end
            default: n_st = tlpc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        load_ev   = 1'b0;
        div_start = 1'b0;
        load_fin  = 1'b0;
        unique case (r_st)
            tlpc_pkg::ST_IDLE: begin
                o_pop     = !i_empty && out_free;
                load_ev   = o_pop && !echo_go;
                div_start = o_pop && echo_go;
            end
            tlpc_pkg::ST_FIN: begin
                load_fin  = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= tlpc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_pump      <= 1'b0;
            r_auto      <= 1'b1;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (div_start) begin
                r_cnt <= tlpc_pkg::CNT_W'(tlpc_pkg::NUM_W);
            end else if (r_st == tlpc_pkg::ST_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (load_ev) begin
                r_pump <= ev_pump;
                r_auto <= ev_auto;
            end else if (load_fin) begin
                r_pump  <= fin_pump;
                r_level <= fin_level;
            end
            if (load_ev || load_fin) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_quo  <= num_mag;
            r_rem  <= '0;
            r_div  <= den_mag;
            r_neg  <= den_pos;
            r_zero <= den_zero;
            r_near <= near;
        end else if (r_st == tlpc_pkg::ST_DIV) begin
            r_quo <= {r_quo[tlpc_pkg::NUM_W-2:0], qbit};
            r_rem <= qbit ? tlpc_pkg::CM_W'(trial - {1'b0, r_div})
                          : trial[tlpc_pkg::CM_W-1:0];
        end
        if (load_ev) begin
            r_out_level <= r_level;
            r_out_upd   <= 1'b0;
            r_out_pump  <= ev_pump;
            r_out_auto  <= ev_auto;
        end else if (load_fin) begin
            r_out_level <= fin_level;
            r_out_upd   <= 1'b1;
            r_out_pump  <= fin_pump;
            r_out_auto  <= r_auto;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.level_percent = r_out_level;
    assign o_res.level_updated = r_out_upd;
    assign o_res.pump_on       = r_out_pump;
    assign o_res.auto_active   = r_out_auto;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("queue popped while empty");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tlpc_pkg::ST_DIV && r_cnt == tlpc_pkg::CNT_W'(1))
            |=> (r_st == tlpc_pkg::ST_FIN))
        else $error("divider did not finish on the last step");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tlpc_pkg::ST_DIV) |-> (r_cnt != '0))
        else $error("divider running with zero steps left");

    a_auto_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != tlpc_pkg::ST_IDLE) |=> $stable(r_auto))
        else $error("mode changed during an echo");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_ev || load_fin) |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten before taken");

endmodule

`default_nettype wire

// ----- hdl/tank_level_pump_controller_unit.sv -----
// top level of the tank level pump controller
// path: button and remote events and out-of-range echoes pass the queue and then the result
// register; an in-range echo also passes the serial divider and its finishing state
// throughput: one event a cycle for non-echo events while results are taken; an in-range
// echo holds the back end for the 17-step serial divider of the level mapping and ST_FIN
// reset (synchronous, active low): pump off, auto mode, level 0, queue empty, config defaults
`default_nettype none

module tank_level_pump_controller_unit #(
    parameter int LOWER_MARGIN_CM = 15
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    tlpc_in_if.sink                                  i_evt,
    tlpc_out_if.source                               o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [tlpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tlpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers, the user must write them only while the block is idle; not enforced
    tlpc_pkg::t_cfg     r_cfg;

    // front to queue
    logic               push;
    tlpc_pkg::t_item    item;
    logic               full;

    // queue to back
    logic               pop;
    tlpc_pkg::t_item    head;
    logic               empty;

    // config write port, unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_cm <= tlpc_pkg::EMPTY_RST;
            r_cfg.full_cm  <= tlpc_pkg::FULL_RST;
            r_cfg.trigger  <= tlpc_pkg::TRIGGER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlpc_pkg::CFG_EMPTY:   r_cfg.empty_cm <= i_cfg_data;
                tlpc_pkg::CFG_FULL:    r_cfg.full_cm  <= i_cfg_data;
                tlpc_pkg::CFG_TRIGGER: r_cfg.trigger  <= i_cfg_data[tlpc_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: decode the event code, scale echo time to Q8 cm
    tlpc_front u_front (
        .i_evt  (i_evt),
        .i_full (full),
        .o_push (push),
        .o_item (item)
    );

    // two-entry queue lets the front keep taking beats while the divider runs, until it is full
    tlpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    // back: state updates, level mapping, result register
    tlpc_back #(
        .LOWER_MARGIN_CM (LOWER_MARGIN_CM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
